>>> rtl/rci_pkg.sv
package rci_pkg;

    // Width of a node index field on the ports
    localparam int NODE_W = 6;
    localparam int MODE_W = 2;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_CHECKED   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UNCHECKED = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE      = 2'd3;

    // Flags the row unit reports on the row it is given
    typedef struct packed {
        logic src_bit;   // row reaches the source node
        logic dst_bit;   // row reaches the target node
        logic upd;       // row must take the target row in
    } t_row_flags;

endpackage

>>> rtl/incremental_reachability_closure_core.sv
// Incremental reachability closure over NODES nodes, kept as a bit matrix
// in a single-port-write, single-port-read row memory.
//
// Input channel: a word (i_mode, i_from_node, i_to_node) is taken at a
// rising edge where start is high and busy is low. busy stays high until
// the word's result has been produced.
// Output channel: each word gives exactly one result; o_answer is valid for
// the single cycle o_valid is high and must be taken then.
//
// Mode three or a node at or above NODES answers in the cycle after the
// accept. A query, or a checked insert that would close a cycle, answers
// from one row read. An insert sweeps every row through the shared row
// unit, one row read per cycle, writing back each row that takes the
// target row in. The next word can be taken in the cycle o_valid shows.
//
// Reset: synchronous, active low. After reset the memory is written to
// identity one row per cycle, with busy high throughout.
module incremental_reachability_closure_core
    import rci_pkg::*;
#(
    parameter int NODES = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [NODE_W-1:0] i_from_node,
    input  logic [NODE_W-1:0] i_to_node,
    output logic              o_valid,
    output logic              o_answer
);

    localparam int IDXW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int CW   = IDXW + 1;
    localparam int CMPW = (CW > NODE_W) ? CW : NODE_W;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_SWEEP
    } t_state;

    t_state            r_state;
    logic [CW-1:0]     r_cnt;
    logic              r_pend;
    logic [IDXW-1:0]   r_wa;
    logic [MODE_W-1:0] r_mode;
    logic [IDXW-1:0]   r_src;
    logic [IDXW-1:0]   r_dst;
    logic [NODES-1:0]  r_row_dst;
    logic              r_valid;
    logic              r_answer;
    logic              n_valid;

    logic [CMPW-1:0]   src_ext;
    logic [CMPW-1:0]   dst_ext;
    logic              in_range;
    logic [IDXW-1:0]   src_idx;
    logic [IDXW-1:0]   dst_idx;

    logic              mem_we;
    logic [IDXW-1:0]   mem_waddr;
    logic [NODES-1:0]  mem_wdata;
    logic [IDXW-1:0]   mem_raddr;
    logic [NODES-1:0]  mem_rdata;
    logic [NODES-1:0]  merged_row;
    logic [NODES-1:0]  ident_row;
    t_row_flags        flags;

    // Range check the incoming node indices
    assign src_ext  = CMPW'(i_from_node);
    assign dst_ext  = CMPW'(i_to_node);
    assign in_range = (src_ext < CMPW'(NODES)) && (dst_ext < CMPW'(NODES));
    assign src_idx  = src_ext[IDXW-1:0];
    assign dst_idx  = dst_ext[IDXW-1:0];

    assign ident_row = NODES'(1) << r_cnt[IDXW-1:0];

    // Select the read row for the current step
    always_comb begin
        unique case (r_state)
            S_IDLE:  mem_raddr = (i_mode == MODE_QUERY) ? src_idx : dst_idx;
            S_SWEEP: mem_raddr = r_cnt[IDXW-1:0];
            default: mem_raddr = r_src;
        endcase
    end

    // Select the write row: identity during clearing, merged row in the sweep
    always_comb begin
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_cnt[IDXW-1:0];
                mem_wdata = ident_row;
            end
            S_SWEEP: begin
                mem_we    = r_pend & flags.upd;
                mem_waddr = r_wa;
                mem_wdata = merged_row;
            end
            default: begin
                mem_we    = 1'b0;
                mem_waddr = r_wa;
                mem_wdata = merged_row;
            end
        endcase
    end

    // Raise the strobe when the current word is done
    always_comb begin
        unique case (r_state)
            S_IDLE:  n_valid = start && (!in_range || i_mode == MODE_NONE);
            S_LOOK:  n_valid = (r_mode == MODE_QUERY) ||
                               (r_mode == MODE_CHECKED && flags.src_bit);
            S_SWEEP: n_valid = (r_cnt == CW'(NODES));
            default: n_valid = 1'b0;
        endcase
    end

    rci_row_ram #(
        .NODES (NODES),
        .IDXW  (IDXW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    rci_row_unit #(
        .NODES (NODES),
        .IDXW  (IDXW)
    ) u_unit (
        .i_row     (mem_rdata),
        .i_row_dst (r_row_dst),
        .i_src     (r_src),
        .i_dst     (r_dst),
        .o_row     (merged_row),
        .o_flags   (flags)
    );

    // Sequencer: clear, take a word, look up one row, sweep all rows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
            unique case (r_state)
                S_CLEAR: begin
                    if (r_cnt == CW'(NODES - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        if (!in_range || i_mode == MODE_NONE) begin
                            r_answer <= 1'b0;
                        end else begin
                            r_mode  <= i_mode;
                            r_src   <= src_idx;
                            r_dst   <= dst_idx;
                            r_state <= S_LOOK;
                        end
                    end
                end
                S_LOOK: begin
                    if (r_mode == MODE_QUERY) begin
                        r_answer <= flags.dst_bit;
                        r_state  <= S_IDLE;
                    end else if (r_mode == MODE_CHECKED && flags.src_bit) begin
                        // target already reaches source: refuse
                        r_answer <= 1'b0;
                        r_state  <= S_IDLE;
                    end else begin
                        r_row_dst <= mem_rdata;
                        r_cnt     <= '0;
                        r_pend    <= 1'b0;
                        r_state   <= S_SWEEP;
                    end
                end
                S_SWEEP: begin
                    if (r_cnt == CW'(NODES)) begin
                        r_answer <= 1'b1;
                        r_pend   <= 1'b0;
                        r_cnt    <= '0;
                        r_state  <= S_IDLE;
                    end else begin
                        r_cnt  <= r_cnt + 1'b1;
                        r_pend <= 1'b1;
                        r_wa   <= r_cnt[IDXW-1:0];
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_answer = r_answer;

endmodule

>>> rtl/rci_row_ram.sv
module rci_row_ram
    import rci_pkg::*;
#(
    parameter int NODES = 64,
    parameter int IDXW  = 6
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDXW-1:0]  i_waddr,
    input  logic [NODES-1:0] i_wdata,
    input  logic [IDXW-1:0]  i_raddr,
    output logic [NODES-1:0] o_rdata
);

    // One row of reachability bits per node
    logic [NODES-1:0] mem [NODES];

    // Write one row, read one row with registered data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

>>> rtl/rci_row_unit.sv
module rci_row_unit
    import rci_pkg::*;
#(
    parameter int NODES = 64,
    parameter int IDXW  = 6
) (
    input  logic [NODES-1:0] i_row,
    input  logic [NODES-1:0] i_row_dst,
    input  logic [IDXW-1:0]  i_src,
    input  logic [IDXW-1:0]  i_dst,
    output logic [NODES-1:0] o_row,
    output t_row_flags       o_flags
);

    // Pick the two bits of interest out of the row
    assign o_flags.src_bit = i_row[i_src];
    assign o_flags.dst_bit = i_row[i_dst];

    // A row that reaches the source but not yet the target takes the target row in
    assign o_flags.upd = o_flags.src_bit & ~o_flags.dst_bit;
    assign o_row       = i_row | i_row_dst;

endmodule

>>> rtl/rci_checker.sv
module rci_checker
    import rci_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic [MODE_W-1:0] i_mode,
    input logic              o_valid,
    input logic              o_answer
);

    // A result only shows while the block is ready for the next word
    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while busy");

    // An accepted word either starts work or answers at once
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_valid))
        else $error("accepted word dropped");

    // Mode three answers 0 in the next cycle
    a_mode_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_mode == MODE_NONE) |=> (o_valid && !o_answer))
        else $error("mode three misanswered");

    // No result without a word accepted or in work
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(busy) || $past(start)))
        else $error("result without a word");

endmodule

bind incremental_reachability_closure_core rci_checker u_rci_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_mode   (i_mode),
    .o_valid  (o_valid),
    .o_answer (o_answer)
);
